>>> design/hot_sector_hit_suppressor_macros.svh
// Assertion helpers used by the hot_sector_hit_suppressor design file.
`ifndef HOT_SECTOR_HIT_SUPPRESSOR_MACROS_SVH
`define HOT_SECTOR_HIT_SUPPRESSOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HSH_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define HSH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/hsh_pkg.sv
package hsh_pkg;

  // Field widths
  localparam int ID_W     = 16;
  localparam int SECTOR_W = 8;
  localparam int SIZE_W   = 8;
  localparam int OCC_W    = 13;

  // Store geometry
  localparam int MAX_HITS    = 32;
  localparam int NUM_SECTORS = 256;
  localparam int CNT_W       = 6;
  localparam int IDX_W       = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
  localparam int SLOT_W      = $clog2(NUM_SECTORS);

  localparam logic [OCC_W-1:0] OCC_MAX   = 13'd8191;
  localparam logic [OCC_W-1:0] OCC_RESET = 13'd48;
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(MAX_HITS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_W_HIT,
    ST_W_OCC,
    ST_W_CMP,
    ST_W_SUM
  } hsh_state_t;

  typedef struct packed {
    logic [ID_W-1:0]     hit_id;
    logic [SECTOR_W-1:0] sector;
  } hit_entry_t;

  // Occupancy slot of a sector
  function automatic logic [SLOT_W-1:0] sector_slot(input logic [SECTOR_W-1:0] sec);
    return SLOT_W'(32'(sec) % NUM_SECTORS);
  endfunction

endpackage

>>> design/hsh_hit_if.sv
interface hsh_hit_if import hsh_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ID_W-1:0]     hit_id;
  logic [SECTOR_W-1:0] sector;
  logic [SIZE_W-1:0]   pseudo_size;
  logic                is_last;

  modport source (output valid, hit_id, sector, pseudo_size, is_last, input ready);
  modport sink   (input valid, hit_id, sector, pseudo_size, is_last, output ready);
endinterface

>>> design/hsh_res_if.sv
interface hsh_res_if import hsh_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ID_W-1:0]     kept_hit_id;
  logic [SECTOR_W-1:0] kept_sector;
  logic                is_summary;
  logic [CNT_W-1:0]    removed_count;
  logic                overflow;
  logic                last_result;

  modport source (output valid, kept_hit_id, kept_sector, is_summary, removed_count,
                  overflow, last_result, input ready);
  modport sink   (input valid, kept_hit_id, kept_sector, is_summary, removed_count,
                  overflow, last_result, output ready);
endinterface

>>> design/hot_sector_hit_suppressor.sv
// Channel   Dir  Carries
// in_ch     in   one hit: hit_id, sector, pseudo_size, is_last
// out_ch    out  kept hit, or closing summary (removed_count, overflow)
// cfg_*     in   max_occupancy write, 13 bits
//
// A stored hit takes an occupancy read, then a saturating write back;
// a hit dropped on a full store only sets the overflow flag.
// After the last hit the walk takes each stored hit through a hit store read,
// an occupancy read and a compare, then issues the summary; output stalls hold it.
// The occupancy read is registered, and the walk's occupancy read depends on its hit store read.
// Reset is synchronous and clears all occupancy sums at once through valid bits.
// in_ch.ready is low during accumulate and walk; a stalled result holds the walk.
`include "hot_sector_hit_suppressor_macros.svh"

module hot_sector_hit_suppressor import hsh_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  hsh_hit_if.sink          in_ch,
  hsh_res_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [OCC_W-1:0] cfg_wdata
);

  hsh_state_t state_r, state_nxt;

  logic [OCC_W-1:0]    max_occ_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                ovf_r;
  logic [IDX_W-1:0]    idx_r;
  logic [CNT_W-1:0]    removed_r;
  logic [SIZE_W-1:0]   acc_size_r;
  logic                acc_last_r;
  logic [SLOT_W-1:0]   occ_slot_r;
  logic [NUM_SECTORS-1:0] occ_vld_r;

  hit_entry_t          hit_mem [MAX_HITS];
  hit_entry_t          hit_rd_r;
  logic [OCC_W-1:0]    occ_mem [NUM_SECTORS];
  logic [OCC_W-1:0]    occ_rd_r;

  logic                out_vld_r;
  logic [ID_W-1:0]     out_id_r;
  logic [SECTOR_W-1:0] out_sec_r;
  logic                out_sum_r;
  logic [CNT_W-1:0]    out_rem_r;
  logic                out_ovf_r;

  // Handshake and datapath terms
  logic              in_xfer;
  logic              out_free;
  logic              full;
  logic [OCC_W-1:0]  occ_cur;
  logic [OCC_W:0]    occ_sum;
  logic [OCC_W-1:0]  occ_new;
  logic              keep;
  logic              walk_end;
  logic [SLOT_W-1:0] occ_rd_slot;

  // Sequencer controls
  logic in_rdy;
  logic hit_we;
  logic hit_re;
  logic occ_re;
  logic occ_we;
  logic ovf_set;
  logic load_kept;
  logic rem_inc;
  logic idx_adv;
  logic load_sum;

  assign in_xfer  = in_ch.valid && in_rdy;
  assign out_free = !out_vld_r || out_ch.ready;
  assign full     = (cnt_r == CNT_FULL);

  // Current occupancy of the slot last read; an invalid slot reads as zero
  assign occ_cur = occ_vld_r[occ_slot_r] ? occ_rd_r : '0;
  assign occ_sum = {1'b0, occ_cur} + (OCC_W+1)'(acc_size_r);
  assign occ_new = (occ_sum > {1'b0, OCC_MAX}) ? OCC_MAX : occ_sum[OCC_W-1:0];
  assign keep    = (occ_cur <= max_occ_r);

  assign walk_end    = ((CNT_W'(idx_r) + CNT_W'(1)) == cnt_r);
  assign occ_rd_slot = (state_r == ST_IDLE) ? sector_slot(in_ch.sector)
                                            : sector_slot(hit_rd_r.sector);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (!full) begin
            state_nxt = ST_ACC;
          end else if (in_ch.is_last) begin
            state_nxt = ST_W_HIT;
          end
        end
      end
      ST_ACC:   state_nxt = acc_last_r ? ST_W_HIT : ST_IDLE;
      ST_W_HIT: state_nxt = ST_W_OCC;
      ST_W_OCC: state_nxt = ST_W_CMP;
      ST_W_CMP: begin
        if (!keep || out_free) begin
          state_nxt = walk_end ? ST_W_SUM : ST_W_HIT;
        end
      end
      ST_W_SUM: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_rdy    = 1'b0;
    hit_we    = 1'b0;
    hit_re    = 1'b0;
    occ_re    = 1'b0;
    occ_we    = 1'b0;
    ovf_set   = 1'b0;
    load_kept = 1'b0;
    rem_inc   = 1'b0;
    idx_adv   = 1'b0;
    load_sum  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_rdy = 1'b1;
        if (in_ch.valid) begin
          hit_we  = !full;
          occ_re  = !full;
          ovf_set = full;
        end
      end
      ST_ACC:   occ_we = 1'b1;
      ST_W_HIT: hit_re = 1'b1;
      ST_W_OCC: occ_re = 1'b1;
      ST_W_CMP: begin
        if (keep) begin
          load_kept = out_free;
          idx_adv   = out_free;
        end else begin
          rem_inc = 1'b1;
          idx_adv = 1'b1;
        end
      end
      ST_W_SUM: load_sum = out_free;
      default: begin
      end
    endcase
  end

  // Hold the state and the per-event counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      max_occ_r <= OCC_RESET;
      cnt_r     <= '0;
      ovf_r     <= 1'b0;
      idx_r     <= '0;
      removed_r <= '0;
      occ_vld_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        max_occ_r <= cfg_wdata;
      end
      if (hit_we) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (ovf_set) begin
        ovf_r <= 1'b1;
      end
      if (occ_we) begin
        occ_vld_r[occ_slot_r] <= 1'b1;
      end
      if (rem_inc) begin
        removed_r <= removed_r + CNT_W'(1);
      end
      if (idx_adv) begin
        idx_r <= walk_end ? '0 : idx_r + IDX_W'(1);
      end
      // Close the event: every used slot returns to zero
      if (load_sum) begin
        cnt_r     <= '0;
        ovf_r     <= 1'b0;
        removed_r <= '0;
        occ_vld_r <= '0;
      end
    end
  end

  // Latch the hit being accumulated
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      acc_size_r <= in_ch.pseudo_size;
      acc_last_r <= in_ch.is_last;
    end
    if (occ_re) begin
      occ_slot_r <= occ_rd_slot;
    end
  end

  // Hit store, written in arrival order, read by the walk
  always_ff @(posedge clk) begin
    if (hit_we) begin
      hit_mem[cnt_r[IDX_W-1:0]] <= '{hit_id: in_ch.hit_id, sector: in_ch.sector};
    end
    if (hit_re) begin
      hit_rd_r <= hit_mem[idx_r];
    end
  end

  // Occupancy memory, one read and one write port
  always_ff @(posedge clk) begin
    if (occ_we) begin
      occ_mem[occ_slot_r] <= occ_new;
    end
    if (occ_re) begin
      occ_rd_r <= occ_mem[occ_rd_slot];
    end
  end

  // Output register: load a kept hit or the summary when the slot frees
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (load_kept || load_sum) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_kept) begin
      out_id_r  <= hit_rd_r.hit_id;
      out_sec_r <= hit_rd_r.sector;
      out_sum_r <= 1'b0;
      out_rem_r <= '0;
      out_ovf_r <= 1'b0;
    end else if (load_sum) begin
      out_id_r  <= '0;
      out_sec_r <= '0;
      out_sum_r <= 1'b1;
      out_rem_r <= removed_r;
      out_ovf_r <= ovf_r;
    end
  end

  assign in_ch.ready          = in_rdy;
  assign out_ch.valid         = out_vld_r;
  assign out_ch.kept_hit_id   = out_id_r;
  assign out_ch.kept_sector   = out_sec_r;
  assign out_ch.is_summary    = out_sum_r;
  assign out_ch.removed_count = out_rem_r;
  assign out_ch.overflow      = out_ovf_r;
  assign out_ch.last_result   = out_sum_r;

  `HSH_ASSERT_NOW(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CNT_FULL, "hit count beyond store")
  `HSH_ASSERT_NOW(a_walk_idx, clk, rst_n, state_r == ST_W_HIT, CNT_W'(idx_r) < cnt_r, "walk index past stored hits")
  `HSH_ASSERT_NEXT(a_ovf_set, clk, rst_n, in_xfer && full, ovf_r, "dropped hit did not flag overflow")
  `HSH_ASSERT_NEXT(a_event_clear, clk, rst_n, load_sum, (cnt_r == '0) && !ovf_r && (occ_vld_r == '0), "event state not cleared after summary")
  `HSH_ASSERT_NOW(a_load_free, clk, rst_n, load_kept || load_sum, out_free, "result loaded over a pending transfer")

endmodule

>>> bench/hsh_result_checker.sv
module hsh_result_checker import hsh_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  hsh_hit_if               in_ch,
  hsh_res_if               out_ch,
  input  logic             cfg_we,
  input  logic [OCC_W-1:0] cfg_wdata,
  output int               fail_count,
  output int               pending
);

  typedef struct packed {
    logic [ID_W-1:0]     hit_id;
    logic [SECTOR_W-1:0] sector;
    logic                summary;
    logic [CNT_W-1:0]    removed;
    logic                ovf;
    logic                last;
  } result_t;

  // Predicted event state
  logic [ID_W-1:0]     held_ids     [MAX_HITS];
  logic [SECTOR_W-1:0] held_sectors [MAX_HITS];
  logic [OCC_W-1:0]    occ_sum      [NUM_SECTORS];
  int                  held_count;
  logic                dropped_any;
  logic [OCC_W-1:0]    occ_limit;

  result_t due_results [$];
  int      mismatches = 0;

  assign fail_count = mismatches;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  // Collect one hit; on the last hit, walk the store and queue the results
  task automatic collect_hit(input logic [ID_W-1:0] id, input logic [SECTOR_W-1:0] sec,
                             input logic [SIZE_W-1:0] size, input logic last);
    int      slot;
    int      total;
    int      removed;
    result_t r;
    if (held_count >= MAX_HITS) begin
      dropped_any = 1'b1;
    end else begin
      held_ids[held_count]     = id;
      held_sectors[held_count] = sec;
      held_count++;
      slot  = int'(sec) % NUM_SECTORS;
      total = int'(occ_sum[slot]) + int'(size);
      occ_sum[slot] = (total > int'(OCC_MAX)) ? OCC_MAX : OCC_W'(total);
    end
    if (!last) return;

    // Keep hits of quiet sectors in arrival order
    removed = 0;
    for (int i = 0; i < held_count; i++) begin
      slot = int'(held_sectors[i]) % NUM_SECTORS;
      if (occ_sum[slot] <= occ_limit) begin
        r        = '0;
        r.hit_id = held_ids[i];
        r.sector = held_sectors[i];
        due_results = {due_results, r};
      end else begin
        removed++;
      end
    end
    r         = '0;
    r.summary = 1'b1;
    r.removed = CNT_W'(removed);
    r.ovf     = dropped_any;
    r.last    = 1'b1;
    due_results = {due_results, r};

    // Clear the sums this event touched
    for (int i = 0; i < held_count; i++)
      occ_sum[int'(held_sectors[i]) % NUM_SECTORS] = '0;
    held_count  = 0;
    dropped_any = 1'b0;
  endtask

  task automatic compare_result();
    result_t want;
    if (due_results.size() == 0) begin
      report_mismatch($sformatf("result with nothing due: id %h sector %h summary %b",
                                out_ch.kept_hit_id, out_ch.kept_sector, out_ch.is_summary));
      return;
    end
    want = due_results.pop_front();
    if (out_ch.kept_hit_id !== want.hit_id)
      report_mismatch($sformatf("kept_hit_id %h, want %h", out_ch.kept_hit_id, want.hit_id));
    if (out_ch.kept_sector !== want.sector)
      report_mismatch($sformatf("kept_sector %h, want %h", out_ch.kept_sector, want.sector));
    if (out_ch.is_summary !== want.summary)
      report_mismatch($sformatf("is_summary %b, want %b", out_ch.is_summary, want.summary));
    if (out_ch.removed_count !== want.removed)
      report_mismatch($sformatf("removed_count %0d, want %0d",
                                out_ch.removed_count, want.removed));
    if (out_ch.overflow !== want.ovf)
      report_mismatch($sformatf("overflow %b, want %b", out_ch.overflow, want.ovf));
    if (out_ch.last_result !== want.last)
      report_mismatch($sformatf("last_result %b, want %b", out_ch.last_result, want.last));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (occ_sum[i]) occ_sum[i] = '0;
      held_count  = 0;
      dropped_any = 1'b0;
      occ_limit   = OCC_RESET;
      due_results.delete();
    end else begin
      // Check results before queueing new ones
      if (out_ch.valid && out_ch.ready)
        compare_result();
      if (cfg_we)
        occ_limit = cfg_wdata;
      if (in_ch.valid && in_ch.ready)
        collect_hit(in_ch.hit_id, in_ch.sector, in_ch.pseudo_size, in_ch.is_last);
    end
    pending <= due_results.size();
  end

endmodule

>>> bench/tb_hot_sector_hit_suppressor.sv
module tb_hot_sector_hit_suppressor;
  import hsh_pkg::*;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [OCC_W-1:0] cfg_wdata;
  logic             sink_ready = 1'b0;
  int               fail_count;
  int               pending;
  int               burst_left = 0;

  hsh_hit_if in_ch ();
  hsh_res_if out_ch ();

  assign out_ch.ready = sink_ready;

  hot_sector_hit_suppressor uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  hsh_result_checker occupancy_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver stall pattern: pick a new random mode each time the tick counter wraps
  logic [5:0] stall_tick = '0;
  logic [1:0] stall_mode = '0;

  always @(posedge clk) begin
    stall_tick <= stall_tick + 6'd1;
    if (stall_tick == 6'd63)
      stall_mode <= 2'($urandom_range(0, 3));
    case (stall_mode)
      2'd0: sink_ready <= 1'b1;
      2'd1: sink_ready <= ($urandom_range(0, 1) == 1);
      2'd2: sink_ready <= (stall_tick[2:0] == 3'd0);
      default: sink_ready <= ($urandom_range(0, 9) != 0);
    endcase
  end

  // Offer one hit and hold it until the transfer; gaps fall between bursts
  task automatic send_hit(input logic [ID_W-1:0] id, input logic [SECTOR_W-1:0] sec,
                          input logic [SIZE_W-1:0] size, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid       <= 1'b1;
    in_ch.hit_id      <= id;
    in_ch.sector      <= sec;
    in_ch.pseudo_size <= size;
    in_ch.is_last     <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Drop valid and hold until every due result has arrived
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_limit(input logic [OCC_W-1:0] value);
    drain_results();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // One event: hot mode crowds a few sectors, wide mode spans every field
  task automatic send_event(input int n_hits, input bit wide);
    logic [SECTOR_W-1:0] pool [3];
    logic [SECTOR_W-1:0] sec;
    logic [SIZE_W-1:0]   size;
    foreach (pool[i]) pool[i] = SECTOR_W'($urandom);
    for (int k = 0; k < n_hits; k++) begin
      if (wide) begin
        sec  = SECTOR_W'($urandom);
        size = SIZE_W'($urandom);
      end else begin
        sec  = pool[$urandom_range(0, 2)];
        size = ($urandom_range(0, 4) == 0) ? '0 : SIZE_W'($urandom_range(1, 40));
      end
      send_hit(ID_W'($urandom), sec, size, k == n_hits - 1);
    end
  endtask

  initial begin
    #(12 * 400000);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    logic [OCC_W-1:0] phase_limit;
    int               phase_items;
    int               n;

    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.hit_id      = '0;
    in_ch.sector      = '0;
    in_ch.pseudo_size = '0;
    in_ch.is_last     = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed events at the reset threshold
    send_hit(16'hFFFF, 8'hFF, 8'hFF, 1'b1);
    send_hit(16'h0000, 8'h00, 8'h00, 1'b1);
    // Sum exactly at the threshold stays, one above goes
    send_hit(16'h1111, 8'h07, 8'd20, 1'b0);
    send_hit(16'h2222, 8'h08, 8'd49, 1'b0);
    send_hit(16'h3333, 8'h07, 8'd28, 1'b0);
    send_hit(16'h4444, 8'h09, 8'd0, 1'b1);
    // Sector used last event starts from zero again
    send_hit(16'h5555, 8'h08, 8'd1, 1'b1);
    send_hit(16'hA5A5, 8'h80, 8'd48, 1'b0);
    send_hit(16'h5A5A, 8'h80, 8'd0, 1'b0);
    send_hit(16'h0F0F, 8'h7F, 8'd47, 1'b1);
    // Every hit suppressed: summary only
    send_hit(16'h8000, 8'h01, 8'h80, 1'b0);
    send_hit(16'h0001, 8'h01, 8'h7F, 1'b1);

    // Random events under several thresholds, extremes included
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: phase_limit = '0;
        1: phase_limit = OCC_MAX;
        2: phase_limit = OCC_W'($urandom_range(1, 150));
        3: phase_limit = OCC_W'($urandom);
        default: phase_limit = OCC_RESET;
      endcase
      set_limit(phase_limit);
      phase_items = 0;
      // Overfill the store once under a tight threshold
      if (p == 2) begin
        n = $urandom_range(33, 38);
        send_event(n, 1'b0);
        phase_items += n;
      end
      while (phase_items < 16) begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 32) : $urandom_range(1, 10);
        send_event(n, $urandom_range(0, 4) == 0);
        phase_items += n;
        if ($urandom_range(0, 5) == 0)
          drain_results();
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/hsh_pkg.sv
design/hsh_hit_if.sv
design/hsh_res_if.sv
design/hot_sector_hit_suppressor.sv
bench/hsh_result_checker.sv
bench/tb_hot_sector_hit_suppressor.sv
